[src/psvm_pkg.sv]
// Package for the polyphonic sample voice mixer.
// Holds sizes, request and envelope codes, payload structs and fixed-point constants.
// Depends on nothing.
`default_nettype none

package psvm_pkg;

	localparam int VOICES      = 8;
	localparam int SLOTS       = 16;
	localparam int SLOT_FRAMES = 4096;

	localparam int VOICE_W = $clog2(VOICES);
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int FRAME_W = $clog2(SLOT_FRAMES);
	localparam int MEM_AW  = SLOT_W + FRAME_W;
	localparam int LEN_W   = FRAME_W + 1;
	localparam int CNT_W   = $clog2(VOICES + 1);

	localparam int POS_W   = 28;
	localparam int LEVEL_W = 17;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;
	localparam logic [POS_W-1:0]   POS_MAX    = 28'hFFFFFFF;

	// floor(2^38 / 127): quotient estimate is exact or one low for 32-bit dividends
	localparam logic [31:0] RECIP_127 = 32'h81020408;
	localparam int          RECIP_SH  = 38;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_MASTER_VOL   = 2'd0;
	localparam logic [1:0] REG_ATTACK_STEP  = 2'd1;
	localparam logic [1:0] REG_RELEASE_STEP = 2'd2;
	localparam logic [1:0] REG_PLAY_STEP    = 2'd3;

	localparam logic [9:0]  MV_RESET  = 10'd256;
	localparam logic [9:0]  MV_MAX    = 10'd512;
	localparam logic [16:0] ATK_RESET = 17'd655;
	localparam logic [16:0] REL_RESET = 17'd131;
	localparam logic [19:0] PS_RESET  = 20'd65536;

	typedef enum logic [2:0] {
		REQ_LOAD     = 3'd0,
		REQ_SET_SLOT = 3'd1,
		REQ_NOTE_ON  = 3'd2,
		REQ_NOTE_OFF = 3'd3,
		REQ_TICK     = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ATTACK  = 2'd1,
		PH_HOLD    = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         slot;
		logic [11:0]        frame_index;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [6:0]         note;
		logic [6:0]         velocity;
		logic [12:0]        slot_length;
		logic               slot_enable;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic [3:0]         active_voices;
	} out_item_t;

endpackage

`default_nettype wire

[src/polyphonic_sample_voice_mixer.sv]
// Top level of the polyphonic sample voice mixer: sequencer, voice state,
// sample memory and one shared 32x32 multiplier. Depends on psvm_pkg.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_stall        in_data  (in_item_t)
//   out      output     out_valid / out_stall      out_data (out_item_t)
//   cfg      input      APB psel/penable/pwrite    paddr, pwdata, prdata
//
// Load frame, set slot and note off are done in the idle state. Note on scans
// the slots, one per cycle. In a tick every playing voice goes through the
// single multiplier seven times and reads two frames from the one-port sample
// memory. Reset clears voices, slots and registers; the sample memory is not
// cleared. A finished mix waits in the output register while the next request
// is taken; a tick waits at its end for that register.
`default_nettype none

module polyphonic_sample_voice_mixer
	import psvm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_NON  = 13'b0000000000010,
		ST_SEL  = 13'b0000000000100,
		ST_ENV  = 13'b0000000001000,
		ST_RD0  = 13'b0000000010000,
		ST_RD1  = 13'b0000000100000,
		ST_G1   = 13'b0000001000000,
		ST_G2   = 13'b0000010000000,
		ST_IL   = 13'b0000100000000,
		ST_IR   = 13'b0001000000000,
		ST_AL   = 13'b0010000000000,
		ST_AR   = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [9:0]  mv_q;
	logic [16:0] atk_q;
	logic [16:0] rel_q;
	logic [19:0] pstep_q;

	// Slot and voice state
	logic [6:0]         slot_note_q [SLOTS];
	logic [LEN_W-1:0]   slot_len_q  [SLOTS];
	logic [SLOTS-1:0]   slot_ld_q;
	logic [VOICES-1:0]  v_act_q;
	logic [SLOT_W-1:0]  v_slot_q  [VOICES];
	logic [6:0]         v_note_q  [VOICES];
	logic [6:0]         v_vel_q   [VOICES];
	logic [POS_W-1:0]   v_pos_q   [VOICES];
	phase_t             v_ph_q    [VOICES];
	logic [LEVEL_W-1:0] v_lvl_q   [VOICES];

	// Sequencer working registers
	logic [VOICE_W-1:0] vi_q;
	logic [SLOT_W-1:0]  si_q;
	logic [6:0]         req_note_q;
	logic [6:0]         req_vel_q;
	logic [63:0]        mul_q;
	logic [31:0]        x_q;
	logic [25:0]        gain_q;
	logic [31:0]        f0_q;
	logic [31:0]        f1_q;
	logic signed [33:0] il_q;
	logic signed [33:0] ir_q;
	logic signed [20:0] accl_q;
	logic signed [20:0] accr_q;
	logic [31:0]        mem_rd_q;
	logic [31:0]        mem [2**MEM_AW];
	out_item_t          out_q;
	logic               out_vld_q;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;

	// Finished mix moves into the output register
	logic mix_load;
	assign mix_load = (state_q == ST_DONE) && (!out_vld_q || !out_stall);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	// Register read-back
	always_comb begin
		unique case (paddr[3:2])
			REG_MASTER_VOL:   prdata = {22'd0, mv_q};
			REG_ATTACK_STEP:  prdata = {15'd0, atk_q};
			REG_RELEASE_STEP: prdata = {15'd0, rel_q};
			REG_PLAY_STEP:    prdata = {12'd0, pstep_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q    <= MV_RESET;
			atk_q   <= ATK_RESET;
			rel_q   <= REL_RESET;
			pstep_q <= PS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MASTER_VOL:   mv_q <= (pwdata[9:0] > MV_MAX) ? MV_MAX : pwdata[9:0];
				REG_ATTACK_STEP:  atk_q <= pwdata[16:0];
				REG_RELEASE_STEP: rel_q <= pwdata[16:0];
				REG_PLAY_STEP:    pstep_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Current voice fields
	logic [LEVEL_W-1:0] cur_lvl;
	logic [POS_W-1:0]   cur_pos;
	logic [SLOT_W-1:0]  cur_slot;
	logic [FRAME_W-1:0] cur_ip;
	logic [15:0]        cur_frac;
	logic [LEN_W-1:0]   cur_len;
	assign cur_lvl  = v_lvl_q[vi_q];
	assign cur_pos  = v_pos_q[vi_q];
	assign cur_slot = v_slot_q[vi_q];
	assign cur_ip   = cur_pos[POS_W-1:16];
	assign cur_frac = cur_pos[15:0];
	assign cur_len  = slot_len_q[cur_slot];

	// Envelope step and end-of-voice checks
	logic [LEVEL_W:0]   atk_sum;
	logic [LEVEL_W-1:0] env_lvl;
	phase_t             env_ph;
	logic               rel_end;
	logic               len_end;
	always_comb begin
		atk_sum = {1'b0, cur_lvl} + {1'b0, atk_q};
		env_lvl = cur_lvl;
		env_ph  = v_ph_q[vi_q];
		rel_end = 1'b0;
		case (v_ph_q[vi_q])
			PH_ATTACK: begin
				if (atk_sum >= {1'b0, FULL_LEVEL}) begin
					env_lvl = FULL_LEVEL;
					env_ph  = PH_HOLD;
				end else begin
					env_lvl = atk_sum[LEVEL_W-1:0];
				end
			end
			PH_RELEASE: begin
				if (cur_lvl <= rel_q) begin
					env_lvl = '0;
					rel_end = 1'b1;
				end else begin
					env_lvl = cur_lvl - rel_q;
				end
			end
			default: ;
		endcase
		len_end = (cur_len < LEN_W'(2)) || ({1'b0, cur_ip} >= cur_len - LEN_W'(1))
			|| (cur_ip == {FRAME_W{1'b1}});
	end

	// Sample differences and magnitudes
	logic signed [16:0] dl, dr;
	logic [15:0]        dl_mag, dr_mag;
	logic [31:0]        il_mag, ir_mag;
	assign dl     = 17'(signed'(f1_q[15:0]))  - 17'(signed'(f0_q[15:0]));
	assign dr     = 17'(signed'(f1_q[31:16])) - 17'(signed'(f0_q[31:16]));
	assign dl_mag = dl[16] ? 16'(-dl) : dl[15:0];
	assign dr_mag = dr[16] ? 16'(-dr) : dr[15:0];
	assign il_mag = il_q[33] ? 32'(-il_q) : il_q[31:0];
	assign ir_mag = ir_q[33] ? 32'(-ir_q) : ir_q[31:0];

	// Shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RD0: begin mul_a = 32'(cur_lvl);      mul_b = 32'(v_vel_q[vi_q]); end
			ST_RD1: begin mul_a = mul_q[31:0];       mul_b = 32'(mv_q); end
			ST_G1:  begin mul_a = mul_q[31:0];       mul_b = RECIP_127; end
			ST_G2:  begin mul_a = 32'(cur_frac);     mul_b = 32'(dl_mag); end
			ST_IL:  begin mul_a = 32'(cur_frac);     mul_b = 32'(dr_mag); end
			ST_IR:  begin mul_a = il_mag;            mul_b = 32'(gain_q); end
			ST_AL:  begin mul_a = ir_mag;            mul_b = 32'(gain_q); end
			default: ;
		endcase
	end

	// Quotient correction for gain / 127
	logic [25:0] gq;
	logic [32:0] grem;
	assign gq   = mul_q[RECIP_SH+25:RECIP_SH];
	assign grem = {1'b0, x_q} - ({7'd0, gq} * 33'd127);

	// Interpolation: s0 * 2^16 +/- frac * |s1 - s0|
	logic signed [33:0] il_new, ir_new;
	assign il_new = ($signed(34'(signed'(f0_q[15:0]))) <<< 16)
		+ (dl[16] ? -$signed({2'b00, mul_q[31:0]}) : $signed({2'b00, mul_q[31:0]}));
	assign ir_new = ($signed(34'(signed'(f0_q[31:16]))) <<< 16)
		+ (dr[16] ? -$signed({2'b00, mul_q[31:0]}) : $signed({2'b00, mul_q[31:0]}));

	logic signed [20:0] contrib;
	assign contrib = $signed({4'd0, mul_q[56:40]});

	// Position advance with saturation
	logic [POS_W:0] pos_sum;
	assign pos_sum = {1'b0, cur_pos} + (POS_W+1)'(pstep_q);

	// Lowest free voice
	logic               free_found;
	logic [VOICE_W-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!v_act_q[v]) begin
				free_found = 1'b1;
				free_idx   = VOICE_W'(v);
			end
		end
	end

	// Active voice count
	logic [CNT_W-1:0] act_cnt;
	always_comb begin
		act_cnt = '0;
		for (int v = 0; v < VOICES; v++)
			act_cnt = act_cnt + CNT_W'(v_act_q[v]);
	end

	function automatic logic signed [15:0] sat16(input logic signed [20:0] a);
		if (a > 21'sd32767)
			return 16'sd32767;
		else if (a < -21'sd32767)
			return -16'sd32767;
		return a[15:0];
	endfunction

	logic last_voice;
	assign last_voice = (vi_q == VOICE_W'(VOICES - 1));

	// Sample memory: write on load, registered read during a tick
	logic [MEM_AW-1:0] rd_addr;
	always_comb begin
		rd_addr = {cur_slot, cur_ip};
		if (state_q == ST_RD1)
			rd_addr = {cur_slot, cur_ip + FRAME_W'(1)};
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == REQ_LOAD)
			mem[{in_data.slot, in_data.frame_index}] <= {in_data.right_sample, in_data.left_sample};
		mem_rd_q <= mem[rd_addr];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_RD1) f0_q <= mem_rd_q;
		if (state_q == ST_G1) begin
			f1_q <= mem_rd_q;
			x_q  <= mul_q[31:0];
		end
		if (state_q == ST_G2)
			gain_q <= (grem >= 33'd127) ? gq + 26'd1 : gq;
		if (state_q == ST_IL) il_q <= il_new;
		if (state_q == ST_IR) ir_q <= ir_new;
		if (accept) begin
			req_note_q <= in_data.note;
			req_vel_q  <= in_data.velocity;
		end
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vi_q      <= '0;
			si_q      <= '0;
			accl_q    <= '0;
			accr_q    <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			slot_ld_q <= '0;
			v_act_q   <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				slot_note_q[s] <= '0;
				slot_len_q[s]  <= '0;
			end
			for (int v = 0; v < VOICES; v++) begin
				v_slot_q[v] <= '0;
				v_note_q[v] <= '0;
				v_vel_q[v]  <= '0;
				v_pos_q[v]  <= '0;
				v_ph_q[v]   <= PH_IDLE;
				v_lvl_q[v]  <= '0;
			end
		end else begin
			if (mix_load)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.req_type)
							REQ_SET_SLOT: begin
								slot_note_q[in_data.slot] <= in_data.note;
								slot_len_q[in_data.slot]  <=
									(in_data.slot_length > LEN_W'(SLOT_FRAMES)) ?
									LEN_W'(SLOT_FRAMES) : in_data.slot_length;
								slot_ld_q[in_data.slot] <= in_data.slot_enable;
							end
							REQ_NOTE_ON: begin
								si_q    <= '0;
								state_q <= ST_NON;
							end
							REQ_NOTE_OFF: begin
								for (int v = 0; v < VOICES; v++)
									if (v_act_q[v] && v_note_q[v] == in_data.note)
										v_ph_q[v] <= PH_RELEASE;
							end
							REQ_TICK: begin
								vi_q    <= '0;
								accl_q  <= '0;
								accr_q  <= '0;
								state_q <= ST_SEL;
							end
							default: ;
						endcase
					end
				end
				ST_NON: begin
					if (slot_ld_q[si_q] && slot_note_q[si_q] == req_note_q) begin
						if (free_found) begin
							v_act_q[free_idx]  <= 1'b1;
							v_slot_q[free_idx] <= si_q;
							v_note_q[free_idx] <= req_note_q;
							v_vel_q[free_idx]  <= req_vel_q;
							v_pos_q[free_idx]  <= '0;
							v_lvl_q[free_idx]  <= '0;
							v_ph_q[free_idx]   <= PH_ATTACK;
						end
						state_q <= ST_IDLE;
					end else if (si_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						si_q <= si_q + SLOT_W'(1);
					end
				end
				ST_SEL: begin
					if (v_act_q[vi_q])
						state_q <= ST_ENV;
					else if (last_voice)
						state_q <= ST_DONE;
					else
						vi_q <= vi_q + VOICE_W'(1);
				end
				ST_ENV: begin
					v_lvl_q[vi_q] <= env_lvl;
					if (rel_end || len_end) begin
						v_act_q[vi_q] <= 1'b0;
						v_ph_q[vi_q]  <= PH_IDLE;
						if (last_voice) begin
							state_q <= ST_DONE;
						end else begin
							vi_q    <= vi_q + VOICE_W'(1);
							state_q <= ST_SEL;
						end
					end else begin
						v_ph_q[vi_q] <= env_ph;
						state_q      <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_G1;
				ST_G1:  state_q <= ST_G2;
				ST_G2:  state_q <= ST_IL;
				ST_IL:  state_q <= ST_IR;
				ST_IR:  state_q <= ST_AL;
				ST_AL: begin
					accl_q  <= il_q[33] ? accl_q - contrib : accl_q + contrib;
					state_q <= ST_AR;
				end
				ST_AR: begin
					accr_q <= ir_q[33] ? accr_q - contrib : accr_q + contrib;
					v_pos_q[vi_q] <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
					if (last_voice) begin
						state_q <= ST_DONE;
					end else begin
						vi_q    <= vi_q + VOICE_W'(1);
						state_q <= ST_SEL;
					end
				end
				ST_DONE: begin
					if (mix_load) begin
						out_q.left_out      <= sat16(accl_q);
						out_q.right_out     <= sat16(accr_q);
						out_q.active_voices <= 4'(act_cnt);
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
